### src/dirty_tile_change_coalescer_unit_defines.svh
// ----------------------------------------------------------------------------
// Dirty tile change coalescer: assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef DIRTY_TILE_CHANGE_COALESCER_UNIT_DEFINES_SVH
`define DIRTY_TILE_CHANGE_COALESCER_UNIT_DEFINES_SVH

// same-cycle implication
`define DTCC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTCC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/dtcc_pkg.sv
// ----------------------------------------------------------------------------
// Dirty tile change coalescer package
// Shared types, codes and constants.
// ----------------------------------------------------------------------------
package dtcc_pkg;

  localparam int CNT_W  = 7;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [7:0] GAP_RESET  = 8'd10;
  localparam logic [9:0] Y_SIZE_MAX = 10'd256;
  localparam logic [9:0] Y_PAD      = 10'd4;

  typedef enum logic [1:0] {
    CMD_CHANGE = 2'd0,
    CMD_FLUSH  = 2'd1,
    CMD_PRIO   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_CELL   = 3'd1,
    KIND_LIST   = 3'd2,
    KIND_REGION = 3'd3,
    KIND_HELD   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_CHUNK_X = 2'd0,
    REG_CHUNK_Z = 2'd1,
    REG_GAP     = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHG_RD,
    ST_CHG_CMP,
    ST_CHG_APP,
    ST_FL_DEC,
    ST_FL_RD,
    ST_FL_EMIT
  } state_t;

  typedef struct packed {
    logic signed [21:0] chunk_x;
    logic signed [21:0] chunk_z;
    logic [7:0]         gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic  chg_start;
    logic  flush_start;
    logic  prio_set;
    logic  rd_issue;
    logic  idx_inc;
    logic  list_append;
    logic  out_load;
    kind_t out_kind;
    logic  out_last;
    logic  clear_list;
    logic  flag_clear;
    logic  gap_reload;
  } ctl_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic cnt_full;
    logic cnt_below_max;
    logic id_match;
    logic idx_last;
    logic hold;
    logic out_free;
  } sts_t;

endpackage

### src/dtcc_regs.sv
// ----------------------------------------------------------------------------
// Dirty tile change coalescer: configuration registers
// APB-style register file for chunk origin and region gap.
// ----------------------------------------------------------------------------
module dtcc_regs
  import dtcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chunk_x   <= '0;
      cfg_r.chunk_z   <= '0;
      cfg_r.gap_ticks <= GAP_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_CHUNK_X: cfg_r.chunk_x   <= pwdata[21:0];
        REG_CHUNK_Z: cfg_r.chunk_z   <= pwdata[21:0];
        REG_GAP:     cfg_r.gap_ticks <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CHUNK_X: prdata = {10'd0, cfg_r.chunk_x};
      REG_CHUNK_Z: prdata = {10'd0, cfg_r.chunk_z};
      REG_GAP:     prdata = {24'd0, cfg_r.gap_ticks};
      default:     prdata = '0;
    endcase
  end

endmodule

### src/dtcc_ctrl.sv
// ----------------------------------------------------------------------------
// Dirty tile change coalescer: controller
// Sequences duplicate scans, list appends and flush result emission.
// ----------------------------------------------------------------------------
module dtcc_ctrl
  import dtcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_cmd,
  output logic       in_stall,
  input  sts_t       sts,
  output ctl_t       ctl
);

  state_t state_r;
  state_t state_nxt;
  logic   in_take;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          unique case (in_cmd)
            CMD_CHANGE: begin
              if (sts.cnt_below_max) begin
                state_nxt = sts.cnt_zero ? ST_CHG_APP : ST_CHG_RD;
              end
            end
            CMD_FLUSH: state_nxt = ST_FL_DEC;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CHG_RD:  state_nxt = ST_CHG_CMP;
      ST_CHG_CMP: begin
        if (sts.id_match) begin
          state_nxt = ST_IDLE;
        end else if (sts.idx_last) begin
          state_nxt = ST_CHG_APP;
        end else begin
          state_nxt = ST_CHG_RD;
        end
      end
      ST_CHG_APP: state_nxt = ST_IDLE;
      ST_FL_DEC: begin
        if (!sts.cnt_zero && !sts.cnt_one && !sts.cnt_full) begin
          state_nxt = ST_FL_RD;
        end else if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FL_RD:   state_nxt = ST_FL_EMIT;
      ST_FL_EMIT: begin
        if (sts.out_free) begin
          state_nxt = sts.idx_last ? ST_IDLE : ST_FL_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl          = '0;
    ctl.out_kind = KIND_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          unique case (in_cmd)
            CMD_CHANGE: ctl.chg_start   = 1'b1;
            CMD_FLUSH:  ctl.flush_start = 1'b1;
            CMD_PRIO:   ctl.prio_set    = 1'b1;
            default: ;
          endcase
        end
      end
      ST_CHG_RD: ctl.rd_issue = 1'b1;
      ST_CHG_CMP: begin
        if (!sts.id_match && !sts.idx_last) begin
          ctl.idx_inc = 1'b1;
        end
      end
      ST_CHG_APP: ctl.list_append = 1'b1;
      ST_FL_DEC: begin
        if (sts.out_free) begin
          ctl.out_last = 1'b1;
          if (sts.cnt_zero) begin
            ctl.out_load   = 1'b1;
            ctl.out_kind   = KIND_NONE;
            ctl.flag_clear = 1'b1;
          end else if (sts.cnt_one) begin
            ctl.out_load   = 1'b1;
            ctl.out_kind   = KIND_CELL;
            ctl.clear_list = 1'b1;
          end else if (sts.cnt_full) begin
            ctl.out_load = 1'b1;
            if (sts.hold) begin
              ctl.out_kind = KIND_HELD;
            end else begin
              ctl.out_kind   = KIND_REGION;
              ctl.clear_list = 1'b1;
              ctl.gap_reload = 1'b1;
            end
          end
        end
      end
      ST_FL_RD: ctl.rd_issue = 1'b1;
      ST_FL_EMIT: begin
        if (sts.out_free) begin
          ctl.out_load   = 1'b1;
          ctl.out_kind   = KIND_LIST;
          ctl.out_last   = sts.idx_last;
          ctl.clear_list = sts.idx_last;
          ctl.idx_inc    = !sts.idx_last;
        end
      end
      default: ;
    endcase
  end

endmodule

### src/dtcc_dp.sv
// ----------------------------------------------------------------------------
// Dirty tile change coalescer: datapath
// Bounding box, change list memory, rate-limit counter and result register.
// ----------------------------------------------------------------------------
module dtcc_dp
  import dtcc_pkg::*;
#(
  parameter int MAX_CHANGES = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [3:0]         in_cell_x,
  input  logic [7:0]         in_cell_y,
  input  logic [3:0]         in_cell_z,
  input  logic               in_allow_region,
  input  cfg_t               cfg,
  input  ctl_t               ctl,
  output sts_t               sts,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [2:0]         out_kind,
  output logic signed [25:0] out_pos_x,
  output logic [7:0]         out_pos_y,
  output logic signed [25:0] out_pos_z,
  output logic [4:0]         out_size_x,
  output logic [8:0]         out_size_y,
  output logic [4:0]         out_size_z,
  output logic [6:0]         out_change_total,
  output logic               out_region_sent,
  output logic               out_last
);

  localparam int AW = (MAX_CHANGES > 1) ? $clog2(MAX_CHANGES) : 1;

  logic [15:0]      list_mem [MAX_CHANGES];
  logic [15:0]      rd_data_r;
  logic [15:0]      id_r;
  logic             allow_r;
  logic [CNT_W-1:0] count_r;
  logic [AW-1:0]    idx_r;
  logic [3:0]       x_min_r, x_max_r, z_min_r, z_max_r;
  logic [7:0]       y_min_r, y_max_r;
  logic [7:0]       gap_r;
  logic             flag_r;

  logic             out_valid_r;
  kind_t            out_kind_r;
  logic [25:0]      out_pos_x_r, out_pos_z_r;
  logic [7:0]       out_pos_y_r;
  logic [4:0]       out_size_x_r, out_size_z_r;
  logic [8:0]       out_size_y_r;
  logic [6:0]       out_total_r;
  logic             out_region_r;
  logic             out_last_r;

  logic             cnt_zero;
  logic [6:0]       y_diff;
  logic [9:0]       y_size_full;
  logic [8:0]       y_size;

  assign cnt_zero = (count_r == '0);

  assign sts.cnt_zero      = cnt_zero;
  assign sts.cnt_one       = (count_r == CNT_W'(1));
  assign sts.cnt_full      = (count_r == CNT_W'(MAX_CHANGES));
  assign sts.cnt_below_max = (count_r < CNT_W'(MAX_CHANGES));
  assign sts.id_match      = (rd_data_r == id_r);
  assign sts.idx_last      = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign sts.hold          = !flag_r && (!allow_r || (gap_r != '0));
  assign sts.out_free      = !out_valid_r || !out_stall;

  // region y extent: rounded to even bounds, padded, clamped
  assign y_diff      = y_max_r[7:1] - y_min_r[7:1];
  assign y_size_full = {2'b00, y_diff, 1'b0} + Y_PAD;
  assign y_size      = (y_size_full > Y_SIZE_MAX) ? Y_SIZE_MAX[8:0] : y_size_full[8:0];

  always_ff @(posedge clk) begin
    if (ctl.list_append) begin
      list_mem[count_r[AW-1:0]] <= id_r;
    end
    if (ctl.rd_issue) begin
      rd_data_r <= list_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.chg_start) begin
      id_r <= {in_cell_x, in_cell_z, in_cell_y};
    end
    if (ctl.flush_start) begin
      allow_r <= in_allow_region;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      x_min_r <= '0;
      x_max_r <= '0;
      y_min_r <= '0;
      y_max_r <= '0;
      z_min_r <= '0;
      z_max_r <= '0;
      gap_r   <= '0;
      flag_r  <= 1'b0;
    end else begin
      if (ctl.chg_start) begin
        if (cnt_zero || in_cell_x < x_min_r) x_min_r <= in_cell_x;
        if (cnt_zero || in_cell_x > x_max_r) x_max_r <= in_cell_x;
        if (cnt_zero || in_cell_y < y_min_r) y_min_r <= in_cell_y;
        if (cnt_zero || in_cell_y > y_max_r) y_max_r <= in_cell_y;
        if (cnt_zero || in_cell_z < z_min_r) z_min_r <= in_cell_z;
        if (cnt_zero || in_cell_z > z_max_r) z_max_r <= in_cell_z;
      end
      if (ctl.chg_start || ctl.flush_start) begin
        idx_r <= '0;
      end else if (ctl.idx_inc) begin
        idx_r <= idx_r + AW'(1);
      end
      if (ctl.flush_start && gap_r != '0) begin
        gap_r <= gap_r - 8'd1;
      end else if (ctl.gap_reload) begin
        gap_r <= cfg.gap_ticks;
      end
      if (ctl.clear_list) begin
        count_r <= '0;
      end else if (ctl.list_append) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (ctl.prio_set) begin
        flag_r <= 1'b1;
      end else if (ctl.clear_list || ctl.flag_clear) begin
        flag_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_kind_r   <= ctl.out_kind;
      out_last_r   <= ctl.out_last;
      out_pos_x_r  <= '0;
      out_pos_y_r  <= '0;
      out_pos_z_r  <= '0;
      out_size_x_r <= '0;
      out_size_y_r <= '0;
      out_size_z_r <= '0;
      out_total_r  <= '0;
      out_region_r <= 1'b0;
      case (ctl.out_kind)
        KIND_CELL: begin
          out_pos_x_r <= {cfg.chunk_x, x_min_r};
          out_pos_y_r <= y_min_r;
          out_pos_z_r <= {cfg.chunk_z, z_min_r};
          out_total_r <= 7'd1;
        end
        KIND_REGION: begin
          out_pos_x_r  <= {cfg.chunk_x, x_min_r};
          out_pos_y_r  <= {y_min_r[7:1], 1'b0};
          out_pos_z_r  <= {cfg.chunk_z, z_min_r};
          out_size_x_r <= {1'b0, x_max_r - x_min_r} + 5'd1;
          out_size_y_r <= y_size;
          out_size_z_r <= {1'b0, z_max_r - z_min_r} + 5'd1;
          out_total_r  <= 7'(MAX_CHANGES);
          out_region_r <= 1'b1;
        end
        KIND_LIST: begin
          out_pos_x_r <= {cfg.chunk_x, rd_data_r[15:12]};
          out_pos_y_r <= rd_data_r[7:0];
          out_pos_z_r <= {cfg.chunk_z, rd_data_r[11:8]};
          out_total_r <= count_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_pos_x        = out_pos_x_r;
  assign out_pos_y        = out_pos_y_r;
  assign out_pos_z        = out_pos_z_r;
  assign out_size_x       = out_size_x_r;
  assign out_size_y       = out_size_y_r;
  assign out_size_z       = out_size_z_r;
  assign out_change_total = out_total_r;
  assign out_region_sent  = out_region_r;
  assign out_last         = out_last_r;

endmodule

### src/dirty_tile_change_coalescer_unit.sv
// ----------------------------------------------------------------------------
// Dirty tile change coalescer
// Collects changed cells of one chunk column and reports them on flush.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one command per transfer. A change
// widens the bounding box and appends the packed cell id to the change list
// unless already listed or the list is full; a prioritise sets the priority
// flag; a flush emits one or more results on the output channel
// (out_valid/out_stall), the final one marked by out_last.
// Sequencing: a prioritise, and a change once the list is full, end in the
// idle state. Otherwise a change passes a read and a compare state per list
// entry scanned, then an append state, or stops at the compare state that
// finds a duplicate; the single read port of the list memory sets this.
// An empty, single-cell or full-list flush loads its one result into the
// output register from the decode state; a list flush loads each result
// from an emit state after a read state. The block takes no new command
// until a flush has placed its last result in the output register.
// Reset clears the list, box, counter and flag and returns the configuration
// to its defaults; the list memory itself needs no clearing. A stalled
// receiver holds the output register and the flush waits without losing
// results. Configuration goes through the APB-style port while idle, which
// binds the user; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module dirty_tile_change_coalescer_unit
  import dtcc_pkg::*;
#(
  parameter int MAX_CHANGES = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [3:0]         in_cell_x,
  input  logic [7:0]         in_cell_y,
  input  logic [3:0]         in_cell_z,
  input  logic               in_allow_region,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_kind,
  output logic signed [25:0] out_pos_x,
  output logic [7:0]         out_pos_y,
  output logic signed [25:0] out_pos_z,
  output logic [4:0]         out_size_x,
  output logic [8:0]         out_size_y,
  output logic [4:0]         out_size_z,
  output logic [6:0]         out_change_total,
  output logic               out_region_sent,
  output logic               out_last
);

  cfg_t cfg;
  ctl_t ctl;
  sts_t sts;

  dtcc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dtcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  dtcc_dp #(
    .MAX_CHANGES (MAX_CHANGES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_cell_x        (in_cell_x),
    .in_cell_y        (in_cell_y),
    .in_cell_z        (in_cell_z),
    .in_allow_region  (in_allow_region),
    .cfg              (cfg),
    .ctl              (ctl),
    .sts              (sts),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_pos_z        (out_pos_z),
    .out_size_x       (out_size_x),
    .out_size_y       (out_size_y),
    .out_size_z       (out_size_z),
    .out_change_total (out_change_total),
    .out_region_sent  (out_region_sent),
    .out_last         (out_last)
  );

endmodule

### src/dtcc_checker.sv
// ----------------------------------------------------------------------------
// Dirty tile change coalescer: port checker
// Port-level properties of the coalescer, bound to the top level.
// ----------------------------------------------------------------------------
`include "dirty_tile_change_coalescer_unit_defines.svh"

module dtcc_checker
  import dtcc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_cmd,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         out_kind,
  input logic signed [25:0] out_pos_x,
  input logic [4:0]         out_size_x,
  input logic               out_region_sent,
  input logic               out_last
);

  logic flush_xfer;
  logic prio_xfer;

  assign flush_xfer = in_valid && !in_stall && (in_cmd == CMD_FLUSH);
  assign prio_xfer  = in_valid && !in_stall && (in_cmd == CMD_PRIO);

  `DTCC_ASSERT_NXT(a_flush_busy, flush_xfer, in_stall, "flush transfer did not stall input")
  `DTCC_ASSERT_NXT(a_prio_free, prio_xfer, !in_stall, "prioritise left input stalled")
  `DTCC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_pos_x), "stalled result changed")
  `DTCC_ASSERT_IMP(a_region_shape, out_valid && (out_kind == KIND_REGION), out_region_sent && out_last && (out_size_x != '0), "malformed region result")

endmodule

bind dirty_tile_change_coalescer_unit dtcc_checker u_checker (.*);

### tb/dirty_tile_change_coalescer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dirty tile change coalescer testbench
// Sends change, prioritise and flush commands through the valid/stall input,
// predicts every result in a behavioral copy of the coalescer and checks each
// transfer on the result side field by field. A short directed table comes
// first, then random command sequences under several register settings, with
// random idle cycles on both sides.
// ----------------------------------------------------------------------------
module dirty_tile_change_coalescer_unit_tb;
  import dtcc_pkg::*;

  localparam int LIST_DEPTH = 10;
  localparam int RUN_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] x;
    logic [7:0] y;
    logic [3:0] z;
    logic       allow;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [25:0] px;
    logic [7:0]  py;
    logic [25:0] pz;
    logic [4:0]  sx;
    logic [8:0]  sy;
    logic [4:0]  sz;
    logic [6:0]  tot;
    logic        reg_sent;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  x;
    logic [7:0]  y;
    logic [3:0]  z;
    logic        allow;
    logic        typed;
    logic [2:0]  kind;
    logic [25:0] px;
    logic [7:0]  py;
    logic [25:0] pz;
    logic [6:0]  tot;
  } dir_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = '0;
  logic [3:0] in_cell_x = '0;
  logic [7:0] in_cell_y = '0;
  logic [3:0] in_cell_z = '0;
  logic in_allow_region = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_kind;
  logic signed [25:0] out_pos_x;
  logic [7:0] out_pos_y;
  logic signed [25:0] out_pos_z;
  logic [4:0] out_size_x;
  logic [8:0] out_size_y;
  logic [4:0] out_size_z;
  logic [6:0] out_change_total;
  logic out_region_sent;
  logic out_last;

  dirty_tile_change_coalescer_unit #(.MAX_CHANGES(LIST_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_cell_x(in_cell_x),
    .in_cell_y(in_cell_y), .in_cell_z(in_cell_z), .in_allow_region(in_allow_region),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_size_x(out_size_x), .out_size_y(out_size_y), .out_size_z(out_size_z),
    .out_change_total(out_change_total), .out_region_sent(out_region_sent),
    .out_last(out_last)
  );

  // predicted coalescer state
  logic [21:0] cfg_chunk_x, cfg_chunk_z;
  logic [7:0]  cfg_gap;
  int          list_len;
  logic [15:0] list_ids [0:LIST_DEPTH-1];
  logic [3:0]  bx_min, bx_max, bz_min, bz_max;
  logic [7:0]  by_min, by_max;
  logic [7:0]  gap_left;
  logic        prio_set;

  res_t due_results [$];
  int err_count = 0;
  int cmds_sent = 0;
  int results_seen = 0;
  int regions_seen = 0;
  int held_seen = 0;
  int settings_run = 0;
  int cycles_run = 0;
  bit calm = 1'b0;
  int span_x0, span_xw, span_y0, span_yw, span_z0, span_zw;

  dir_row_t directed_rows [0:23] = '{
    '{CMD_FLUSH,  4'd0,  8'd0,   4'd0,  1'b0, 1'b1, KIND_NONE, '0, '0, '0, '0},
    '{CMD_PRIO,   4'd0,  8'd0,   4'd0,  1'b0, 1'b0, KIND_NONE, '0, '0, '0, '0},
    '{CMD_FLUSH,  4'd0,  8'd0,   4'd0,  1'b1, 1'b1, KIND_NONE, '0, '0, '0, '0},
    '{CMD_CHANGE, 4'd15, 8'd255, 4'd15, 1'b0, 1'b0, KIND_NONE, '0, '0, '0, '0},
    '{CMD_CHANGE, 4'd15, 8'd255, 4'd15, 1'b1, 1'b0, KIND_NONE, '0, '0, '0, '0},
    '{CMD_FLUSH,  4'd0,  8'd0,   4'd0,  1'b0, 1'b1, KIND_CELL, 26'd15, 8'd255, 26'd15, 7'd1},
    '{CMD_CHANGE, 4'd0,  8'd0,   4'd0,  1'b0, 1'b0, KIND_NONE, '0, '0, '0, '0},
    '{CMD_CHANGE, 4'd15, 8'd255, 4'd15, 1'b0, 1'b0, KIND_NONE, '0, '0, '0, '0},
    '{CMD_UNUSED, 4'd15, 8'd255, 4'd15, 1'b1, 1'b0, KIND_NONE, '0, '0, '0, '0},
    '{CMD_FLUSH,  4'd0,  8'd0,   4'd0,  1'b0, 1'b0, KIND_NONE, '0, '0, '0, '0},
    '{CMD_CHANGE, 4'd0,  8'd0,   4'd0,  1'b0, 1'b0, KIND_NONE, '0, '0, '0, '0},
    '{CMD_CHANGE, 4'd15, 8'd255, 4'd15, 1'b0, 1'b0, KIND_NONE, '0, '0, '0, '0},
    '{CMD_CHANGE, 4'd3,  8'd17,  4'd9,  1'b0, 1'b0, KIND_NONE, '0, '0, '0, '0},
    '{CMD_CHANGE, 4'd8,  8'd128, 4'd4,  1'b0, 1'b0, KIND_NONE, '0, '0, '0, '0},
    '{CMD_CHANGE, 4'd1,  8'd1,   4'd1,  1'b0, 1'b0, KIND_NONE, '0, '0, '0, '0},
    '{CMD_CHANGE, 4'd12, 8'd200, 4'd7,  1'b0, 1'b0, KIND_NONE, '0, '0, '0, '0},
    '{CMD_CHANGE, 4'd5,  8'd64,  4'd13, 1'b0, 1'b0, KIND_NONE, '0, '0, '0, '0},
    '{CMD_CHANGE, 4'd9,  8'd33,  4'd2,  1'b0, 1'b0, KIND_NONE, '0, '0, '0, '0},
    '{CMD_CHANGE, 4'd14, 8'd90,  4'd11, 1'b0, 1'b0, KIND_NONE, '0, '0, '0, '0},
    '{CMD_CHANGE, 4'd6,  8'd250, 4'd0,  1'b0, 1'b0, KIND_NONE, '0, '0, '0, '0},
    '{CMD_FLUSH,  4'd0,  8'd0,   4'd0,  1'b0, 1'b1, KIND_HELD, '0, '0, '0, '0},
    '{CMD_CHANGE, 4'd7,  8'd7,   4'd7,  1'b0, 1'b0, KIND_NONE, '0, '0, '0, '0},
    '{CMD_FLUSH,  4'd0,  8'd0,   4'd0,  1'b1, 1'b0, KIND_NONE, '0, '0, '0, '0},
    '{CMD_FLUSH,  4'd0,  8'd0,   4'd0,  1'b1, 1'b1, KIND_NONE, '0, '0, '0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic queue_result(input res_t r);
    due_results = {due_results, r};
  endtask

  task automatic coalesce_step(input cmd_item_t c);
    res_t r;
    logic [15:0] id;
    logic [8:0] y_lo, y_hi;
    logic [9:0] y_span;
    bit seen;
    r = '0;
    r.last = 1'b1;
    case (c.cmd)
      CMD_CHANGE: begin
        if (list_len == 0) begin
          bx_min = c.x; bx_max = c.x;
          by_min = c.y; by_max = c.y;
          bz_min = c.z; bz_max = c.z;
        end
        if (c.x < bx_min) bx_min = c.x;
        if (c.x > bx_max) bx_max = c.x;
        if (c.y < by_min) by_min = c.y;
        if (c.y > by_max) by_max = c.y;
        if (c.z < bz_min) bz_min = c.z;
        if (c.z > bz_max) bz_max = c.z;
        if (list_len < LIST_DEPTH) begin
          id = {c.x, c.z, c.y};
          seen = 1'b0;
          for (int i = 0; i < list_len; i++)
            if (list_ids[i] == id) seen = 1'b1;
          if (!seen) begin
            list_ids[list_len] = id;
            list_len++;
          end
        end
      end
      CMD_PRIO: prio_set = 1'b1;
      CMD_FLUSH: begin
        if (gap_left != 0) gap_left--;
        if (list_len == 0) begin
          prio_set = 1'b0;
          r.kind = KIND_NONE;
          queue_result(r);
        end else if (list_len == 1) begin
          r.kind = KIND_CELL;
          r.px = {cfg_chunk_x, bx_min};
          r.py = by_min;
          r.pz = {cfg_chunk_z, bz_min};
          r.tot = 7'd1;
          queue_result(r);
          list_len = 0;
          prio_set = 1'b0;
        end else if (list_len == LIST_DEPTH && !prio_set && (!c.allow || gap_left != 0)) begin
          r.kind = KIND_HELD;
          queue_result(r);
        end else if (list_len == LIST_DEPTH) begin
          y_lo = 9'({by_min[7:1], 1'b0});
          y_hi = (9'(by_max[7:1]) + 9'd1) << 1;
          y_span = 10'(y_hi) - 10'(y_lo) + 10'd2;
          if (y_span > 10'd256) y_span = 10'd256;
          r.kind = KIND_REGION;
          r.px = {cfg_chunk_x, bx_min};
          r.py = y_lo[7:0];
          r.pz = {cfg_chunk_z, bz_min};
          r.sx = 5'(bx_max) - 5'(bx_min) + 5'd1;
          r.sy = y_span[8:0];
          r.sz = 5'(bz_max) - 5'(bz_min) + 5'd1;
          r.tot = 7'(LIST_DEPTH);
          r.reg_sent = 1'b1;
          queue_result(r);
          gap_left = cfg_gap;
          list_len = 0;
          prio_set = 1'b0;
        end else begin
          for (int i = 0; i < list_len; i++) begin
            r.kind = KIND_LIST;
            r.px = {cfg_chunk_x, list_ids[i][15:12]};
            r.py = list_ids[i][7:0];
            r.pz = {cfg_chunk_z, list_ids[i][11:8]};
            r.tot = 7'(list_len);
            r.last = (i == list_len - 1);
            queue_result(r);
          end
          list_len = 0;
          prio_set = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_command(input cmd_item_t c);
    if (!calm)
      while ($urandom_range(99) < 28) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    in_cmd <= c.cmd;
    in_cell_x <= c.x;
    in_cell_y <= c.y;
    in_cell_z <= c.z;
    in_allow_region <= c.allow;
    do @(posedge clk); while (in_stall);
    coalesce_step(c);
    if (c.cmd != CMD_UNUSED) cmds_sent++;
  endtask

  function automatic cmd_item_t rand_item(input logic [1:0] cmd);
    cmd_item_t c;
    c = 19'($urandom);
    c.cmd = cmd;
    return c;
  endfunction

  function automatic cmd_item_t pick_change();
    cmd_item_t c;
    c = rand_item(CMD_CHANGE);
    if (list_len != 0 && $urandom_range(3) == 0) begin
      {c.x, c.z, c.y} = list_ids[$urandom_range(list_len - 1)];
    end else begin
      c.x = 4'(span_x0 + $urandom_range(span_xw));
      c.y = 8'(span_y0 + $urandom_range(span_yw));
      c.z = 4'(span_z0 + $urandom_range(span_zw));
    end
    return c;
  endfunction

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CHUNK_X: cfg_chunk_x = data[21:0];
      REG_CHUNK_Z: cfg_chunk_z = data[21:0];
      REG_GAP:     cfg_gap = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [21:0] cx, input logic [21:0] cz,
                            input logic [7:0] gap);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(REG_CHUNK_X, {{10{cx[21]}}, cx});
    apb_write(REG_CHUNK_Z, {{10{cz[21]}}, cz});
    apb_write(REG_GAP, {24'd0, gap});
    settings_run++;
  endtask

  // mix of noise, partial lists and full lists followed by flushes
  task automatic run_random(input int n);
    int stop_at, k, tries;
    stop_at = cmds_sent + n;
    while (cmds_sent < stop_at) begin
      if ($urandom_range(2) == 0) begin
        span_x0 = 0; span_xw = 15;
        span_y0 = 0; span_yw = 255;
        span_z0 = 0; span_zw = 15;
      end else begin
        span_x0 = $urandom_range(15); span_xw = $urandom_range(15 - span_x0);
        span_y0 = $urandom_range(235); span_yw = $urandom_range(255 - span_y0, 20);
        span_z0 = $urandom_range(15); span_zw = $urandom_range(15 - span_z0);
      end
      case ($urandom_range(9))
        0, 1: push_command(rand_item(2'($urandom)));
        2, 3, 4, 5: begin
          k = $urandom_range(LIST_DEPTH - 1, 1);
          repeat (k) push_command(pick_change());
          if ($urandom_range(3) == 0) push_command(rand_item(CMD_PRIO));
          push_command(rand_item(CMD_FLUSH));
        end
        default: begin
          tries = 0;
          while (list_len < LIST_DEPTH && tries < 60) begin
            push_command(pick_change());
            tries++;
          end
          repeat ($urandom_range(3, 1)) begin
            if ($urandom_range(3) == 0) push_command(rand_item(CMD_PRIO));
            push_command(rand_item(CMD_FLUSH));
          end
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(99) < 28);
  end

  task automatic check_field(input string name, input logic [25:0] got,
                             input logic [25:0] want_v);
    if (got !== want_v)
      flag_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                              results_seen, name, got, want_v));
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = due_results.pop_front();
        check_field("kind", out_kind, want.kind);
        check_field("pos_x", out_pos_x, want.px);
        check_field("pos_y", out_pos_y, want.py);
        check_field("pos_z", out_pos_z, want.pz);
        check_field("size_x", out_size_x, want.sx);
        check_field("size_y", out_size_y, want.sy);
        check_field("size_z", out_size_z, want.sz);
        check_field("change_total", out_change_total, want.tot);
        check_field("region_sent", out_region_sent, want.reg_sent);
        check_field("last", out_last, want.last);
        if (want.kind == KIND_REGION) regions_seen++;
        if (want.kind == KIND_HELD) held_seen++;
      end
      results_seen++;
    end
  end

  initial begin
    while (cycles_run < RUN_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles_run,
             due_results.size());
    $display("dirty_tile_change_coalescer_unit_tb NOT OK");
    $finish;
  end

  initial begin
    dir_row_t row;
    res_t typed_res;
    cfg_chunk_x = '0;
    cfg_chunk_z = '0;
    cfg_gap = GAP_RESET;
    list_len = 0;
    bx_min = '0; bx_max = '0; by_min = '0; by_max = '0; bz_min = '0; bz_max = '0;
    gap_left = '0;
    prio_set = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      push_command('{row.cmd, row.x, row.y, row.z, row.allow});
      if (row.typed) begin
        typed_res = '0;
        typed_res.kind = row.kind;
        typed_res.px = row.px;
        typed_res.py = row.py;
        typed_res.pz = row.pz;
        typed_res.tot = row.tot;
        typed_res.last = 1'b1;
        due_results[due_results.size() - 1] = typed_res;
      end
    end

    // chunk extremes, no region gap
    set_config(22'h200000, 22'h1FFFFF, 8'd0);
    run_random(30);
    set_config(22'h1FFFFF, 22'h200000, 8'd255);
    run_random(30);
    set_config(22'($urandom), 22'($urandom), 8'($urandom_range(6, 1)));
    calm = 1'b1;
    run_random(25);
    calm = 1'b0;
    set_config(22'h3FFFFF, 22'd1, 8'd3);
    run_random(30);

    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d commands and %0d checked results over %0d register settings",
             cmds_sent, results_seen, settings_run + 1);
    $display("including %0d region updates and %0d held-back flushes; %0d mismatches",
             regions_seen, held_seen, err_count);
    if (err_count == 0) $display("dirty_tile_change_coalescer_unit_tb OK");
    else $display("dirty_tile_change_coalescer_unit_tb NOT OK");
    $finish;
  end

endmodule
